// ===== rtl/ddrc_pkg.sv =====
package ddrc_pkg;

  // Field widths
  localparam int unsigned PosW   = 32;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned DriveW = 16;
  localparam int unsigned RegW   = 16;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 40;

  // Register indexes
  localparam logic [IdxW-1:0] REG_DIST  = 3'd0;
  localparam logic [IdxW-1:0] REG_CPI   = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX   = 3'd2;
  localparam logic [IdxW-1:0] REG_MIN   = 3'd3;
  localparam logic [IdxW-1:0] REG_SS    = 3'd4;
  localparam logic [IdxW-1:0] REG_SE    = 3'd5;
  localparam logic [IdxW-1:0] REG_GAIN  = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_DIST = 16'd0;
  localparam logic [15:0] RST_CPI  = 16'd256;
  localparam logic [14:0] RST_MAX  = 15'd26214;
  localparam logic [14:0] RST_MIN  = 15'd4915;
  localparam logic [15:0] RST_SS   = 16'd1600;
  localparam logic [15:0] RST_SE   = 16'd400;
  localparam logic [15:0] RST_GAIN = 16'd0;

  // Opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Datapath steps issued by the controller
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_SUM,
    STEP_OFF,
    STEP_TGT,
    STEP_ERR,
    STEP_MAG,
    STEP_CMP,
    STEP_MULR,
    STEP_ABS,
    STEP_SPD,
    STEP_SGN,
    STEP_DRV
  } step_e;

  typedef struct packed {
    logic  load;
    step_e step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic ramp;
    logic div_done;
  } stat_t;

  // Clamp a wide signed sum to Q1.15
  function automatic logic [DriveW-1:0] sat16(input logic signed [33:0] x);
    logic [DriveW-1:0] r;
    if (x > 34'sd32767) begin
      r = 16'h7FFF;
    end else if (x < -34'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ddrc_div.sv =====
module ddrc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [17:0] shifted;
  logic [17:0] trial;
  logic        ge;

  // One quotient bit per cycle, restoring
  assign shifted = {rem_q, num_q[31]};
  assign trial   = shifted - {1'b0, den_i};
  assign ge      = (shifted >= {1'b0, den_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[30:0], ge};
      rem_d = ge ? trial[16:0] : shifted[16:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/ddrc_dp.sv =====
module ddrc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ddrc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [ddrc_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          op_i,
  input  logic [ddrc_pkg::PosW-1:0]     left_pos_i,
  input  logic [ddrc_pkg::PosW-1:0]     right_pos_i,
  input  logic [ddrc_pkg::HeadW-1:0]    heading_i,
  input  logic                          enc_ok_i,
  input  ddrc_pkg::cmd_t                cmd_i,
  output ddrc_pkg::stat_t               stat_o,
  output logic [ddrc_pkg::DriveW-1:0]   left_drive_o,
  output logic [ddrc_pkg::DriveW-1:0]   right_drive_o,
  output logic                          finished_o
);

  // Configuration registers
  logic signed [15:0] dist_q;
  logic [15:0]        cpi_q;
  logic [14:0]        max_q;
  logic [14:0]        min_q;
  logic [15:0]        ss_q;
  logic [15:0]        se_q;
  logic signed [15:0] gain_q;

  // Controller state kept across items
  logic signed [33:0] tgt_q;
  logic signed [15:0] sh_q;

  // Item registers
  logic               op_q;
  logic signed [31:0] lp_q, rp_q;
  logic signed [15:0] hd_q;
  logic               ok_q;

  // Working registers
  logic signed [32:0] sum_q;
  logic signed [16:0] hdiff_q;
  logic signed [33:0] mul_q;
  logic signed [22:0] off_q;
  logic signed [32:0] corr_q;
  logic signed [34:0] err_q;
  logic [34:0]        mag_q;
  logic               neg_q;
  logic               cruise_q, ramp_q;
  logic [16:0]        diff_q, den_q;
  logic               qneg_q;
  logic signed [16:0] spd_q, sgn_q;
  logic [15:0]        left_q, right_q;
  logic               fin_q;

  // Combinational helpers
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_full;
  logic signed [16:0] span;
  logic signed [33:0] rnd_sum;
  logic [16:0]        ss2, se2;
  logic               cruise_d;
  logic signed [33:0] mul_abs;
  logic               div_start;
  logic               div_done;
  logic [31:0]        quo;
  logic signed [16:0] qs;
  logic signed [33:0] lsum, rsum;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= ddrc_pkg::RST_DIST;
      cpi_q  <= ddrc_pkg::RST_CPI;
      max_q  <= ddrc_pkg::RST_MAX;
      min_q  <= ddrc_pkg::RST_MIN;
      ss_q   <= ddrc_pkg::RST_SS;
      se_q   <= ddrc_pkg::RST_SE;
      gain_q <= ddrc_pkg::RST_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddrc_pkg::REG_DIST: dist_q <= cfg_data_i;
        ddrc_pkg::REG_CPI:  cpi_q  <= cfg_data_i;
        ddrc_pkg::REG_MAX:  max_q  <= cfg_data_i[14:0];
        ddrc_pkg::REG_MIN:  min_q  <= cfg_data_i[14:0];
        ddrc_pkg::REG_SS:   ss_q   <= cfg_data_i;
        ddrc_pkg::REG_SE:   se_q   <= cfg_data_i;
        ddrc_pkg::REG_GAIN: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier operands
  assign span = $signed({2'b00, max_q}) - $signed({2'b00, min_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      ddrc_pkg::STEP_SUM: begin
        mul_a = {{2{dist_q[15]}}, dist_q};
        mul_b = $signed({2'b00, cpi_q});
      end
      ddrc_pkg::STEP_OFF: begin
        mul_a = {hdiff_q[16], hdiff_q};
        mul_b = {{2{gain_q[15]}}, gain_q};
      end
      ddrc_pkg::STEP_MULR: begin
        mul_a = {span[16], span};
        mul_b = $signed({1'b0, diff_q});
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Round half counts to nearest, ties away from zero
  assign rnd_sum = mul_q + (mul_q[33] ? 34'sd1023 : 34'sd1024);

  assign ss2      = {ss_q, 1'b0};
  assign se2      = {se_q, 1'b0};
  assign cruise_d = (mag_q > {18'd0, ss2});
  assign mul_abs  = mul_q[33] ? -mul_q : mul_q;
  assign div_start = (cmd_i.step == ddrc_pkg::STEP_ABS);
  assign qs       = qneg_q ? -$signed({1'b0, quo[15:0]}) : $signed({1'b0, quo[15:0]});
  assign lsum     = {{17{sgn_q[16]}}, sgn_q} + {corr_q[32], corr_q};
  assign rsum     = {{17{sgn_q[16]}}, sgn_q} - {corr_q[32], corr_q};

  // Persistent target and start heading
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      sh_q  <= '0;
    end else if (cmd_i.step == ddrc_pkg::STEP_TGT && op_q == ddrc_pkg::OP_START) begin
      tgt_q <= {sum_q[32], sum_q} + {{11{off_q[22]}}, off_q};
      sh_q  <= hd_q;
    end
  end

  // Advance the working registers one step at a time
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      lp_q <= left_pos_i;
      rp_q <= right_pos_i;
      hd_q <= heading_i;
      ok_q <= enc_ok_i;
    end
    unique case (cmd_i.step)
      ddrc_pkg::STEP_SUM: begin
        sum_q   <= {lp_q[31], lp_q} + {rp_q[31], rp_q};
        hdiff_q <= {sh_q[15], sh_q} - {hd_q[15], hd_q};
        mul_q   <= mul_full[33:0];
      end
      ddrc_pkg::STEP_OFF: begin
        off_q <= rnd_sum[33:11];
        mul_q <= mul_full[33:0];
      end
      ddrc_pkg::STEP_TGT: begin
        corr_q <= mul_q[32:0];
      end
      ddrc_pkg::STEP_ERR: begin
        err_q <= {tgt_q[33], tgt_q} - {{2{sum_q[32]}}, sum_q};
      end
      ddrc_pkg::STEP_MAG: begin
        mag_q <= err_q[34] ? 35'(-err_q) : 35'(err_q);
        neg_q <= err_q[34];
      end
      ddrc_pkg::STEP_CMP: begin
        cruise_q <= cruise_d;
        ramp_q   <= !cruise_d && (mag_q > {18'd0, se2});
        diff_q   <= mag_q[16:0] - se2;
        den_q    <= ss2 - se2;
      end
      ddrc_pkg::STEP_MULR: begin
        mul_q <= mul_full[33:0];
      end
      ddrc_pkg::STEP_ABS: begin
        qneg_q <= mul_q[33];
      end
      ddrc_pkg::STEP_SPD: begin
        priority if (cruise_q) begin
          spd_q <= $signed({2'b00, max_q});
        end else if (ramp_q) begin
          spd_q <= $signed({2'b00, min_q}) + qs;
        end else begin
          spd_q <= $signed({2'b00, min_q});
        end
      end
      ddrc_pkg::STEP_SGN: begin
        sgn_q <= neg_q ? -spd_q : spd_q;
      end
      ddrc_pkg::STEP_DRV: begin
        left_q  <= (op_q == ddrc_pkg::OP_START) ? '0 : ddrc_pkg::sat16(lsum);
        right_q <= (op_q == ddrc_pkg::OP_START) ? '0 : ddrc_pkg::sat16(rsum);
        fin_q   <= !ok_q || (mag_q == '0);
      end
      default: ;
    endcase
  end

  ddrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_abs[31:0]),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign stat_o.ramp     = ramp_q;
  assign stat_o.div_done = div_done;

  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign finished_o    = fin_q;

endmodule

// ===== rtl/ddrc_ctrl.sv =====
module ddrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  input  ddrc_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output ddrc_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_OFF  = 4'd2;
  localparam logic [3:0] ST_TGT  = 4'd3;
  localparam logic [3:0] ST_ERR  = 4'd4;
  localparam logic [3:0] ST_MAG  = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_MULR = 4'd7;
  localparam logic [3:0] ST_ABS  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_SPD  = 4'd10;
  localparam logic [3:0] ST_SGN  = 4'd11;
  localparam logic [3:0] ST_DRV  = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state_q, state_d;

  // Sequence the datapath
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    cmd_o.step = ddrc_pkg::STEP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.step = ddrc_pkg::STEP_SUM;
        state_d    = ST_OFF;
      end
      ST_OFF: begin
        cmd_o.step = ddrc_pkg::STEP_OFF;
        state_d    = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.step = ddrc_pkg::STEP_TGT;
        state_d    = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.step = ddrc_pkg::STEP_ERR;
        state_d    = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.step = ddrc_pkg::STEP_MAG;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.step = ddrc_pkg::STEP_CMP;
        state_d    = ST_MULR;
      end
      ST_MULR: begin
        cmd_o.step = ddrc_pkg::STEP_MULR;
        state_d    = stat_i.ramp ? ST_ABS : ST_SPD;
      end
      ST_ABS: begin
        cmd_o.step = ddrc_pkg::STEP_ABS;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_SPD;
        end
      end
      ST_SPD: begin
        cmd_o.step = ddrc_pkg::STEP_SPD;
        state_d    = ST_SGN;
      end
      ST_SGN: begin
        cmd_o.step = ddrc_pkg::STEP_SGN;
        state_d    = ST_DRV;
      end
      ST_DRV: begin
        cmd_o.step = ddrc_pkg::STEP_DRV;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/drive_distance_ramp_controller.sv =====
// Items are processed one at a time: an input is accepted only in idle, and a
// new item waits until the result is emitted. Items whose error lies inside the
// slowdown ramp also pass through the 32-step serial divider. The output
// register holds one result; emission stalls while it is full and not taken.
// Reset (rst_ni low, asynchronous): configuration registers take their default values,
// target and start heading clear to zero, no result is pending.
module drive_distance_ramp_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] left_position, [63:32] right_position, [79:64] heading,
  // [80] encoders_ok, [87:81] zero
  input  logic [ddrc_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] opcode
  input  logic                            s_axis_tuser_i,
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [15:0] left_drive, [31:16] right_drive, [32] finished, [39:33] zero
  output logic [ddrc_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [ddrc_pkg::IdxW-1:0]       cfg_idx_i,
  input  logic [ddrc_pkg::RegW-1:0]       cfg_data_i
);

  ddrc_pkg::cmd_t  cmd;
  ddrc_pkg::stat_t stat;
  logic            out_free;
  logic [15:0]     left_drive, right_drive;
  logic            finished;
  logic            out_valid_q;
  logic [ddrc_pkg::OutDataW-1:0] out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  ddrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  ddrc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (s_axis_tuser_i),
    .left_pos_i    (s_axis_tdata_i[31:0]),
    .right_pos_i   (s_axis_tdata_i[63:32]),
    .heading_i     (s_axis_tdata_i[79:64]),
    .enc_ok_i      (s_axis_tdata_i[80]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .finished_o    (finished)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q <= {7'd0, finished, right_drive, left_drive};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
